### rtl/core/fpfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpfa_pkg
// Shared constants, codes and types of the fixed partition fit allocator.
// ----------------------------------------------------------------------------
package fpfa_pkg;

  localparam int PARTITIONS = 128;
  localparam int SIZE_BITS  = 16;
  localparam int ENTRY_W    = SIZE_BITS + 1;
  localparam int IDX_W      = $clog2(PARTITIONS);
  localparam int CNT_W      = $clog2(PARTITIONS + 1);
  localparam int MODE_W     = 2;
  localparam int POL_W      = 2;
  localparam int REQ_W      = 16;
  localparam int PIDX_W     = 7;

  localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REQUEST = 2'd2;

  localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POL_W-1:0] POL_WORST = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]  request_number;
    logic [PIDX_W-1:0] partition_index;
    logic              granted;
  } result_t;

endpackage

### rtl/core/fpfa_size_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpfa_size_ram
// Partition table, one used mark above each size: one write port, one read
// port, registered read data.
// ----------------------------------------------------------------------------
module fpfa_size_ram (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [fpfa_pkg::IDX_W-1:0]     wr_addr,
  input  logic [fpfa_pkg::ENTRY_W-1:0]   wr_data,
  input  logic [fpfa_pkg::IDX_W-1:0]     rd_addr,
  output logic [fpfa_pkg::ENTRY_W-1:0]   rd_data
);

  logic [fpfa_pkg::ENTRY_W-1:0] mem [fpfa_pkg::PARTITIONS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/core/fpfa_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpfa_engine
// Item decoder, counters and the one-entry-per-cycle fit scan.
// ----------------------------------------------------------------------------
module fpfa_engine (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  logic [fpfa_pkg::MODE_W-1:0]         item_mode,
  input  logic [fpfa_pkg::SIZE_BITS-1:0]      item_size,
  input  logic [fpfa_pkg::POL_W-1:0]          policy,
  output logic                                res_valid,
  input  logic                                res_ready,
  output fpfa_pkg::result_t                   res
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

  state_t                          state_r;
  logic [fpfa_pkg::CNT_W-1:0]      entry_count_r;
  logic [fpfa_pkg::REQ_W-1:0]      request_count_r;
  logic [fpfa_pkg::SIZE_BITS-1:0]  req_size_r;
  logic [fpfa_pkg::IDX_W-1:0]      cmp_idx_r;
  logic                            found_r;
  logic [fpfa_pkg::IDX_W-1:0]      pick_r;
  logic [fpfa_pkg::SIZE_BITS-1:0]  pick_size_r;

  logic                            accept;
  logic                            load_wr;
  logic                            mark_wr;
  logic                            wr_en;
  logic [fpfa_pkg::IDX_W-1:0]      wr_addr;
  logic [fpfa_pkg::ENTRY_W-1:0]    wr_data;
  logic [fpfa_pkg::IDX_W-1:0]      rd_addr;
  logic [fpfa_pkg::ENTRY_W-1:0]    rd_data;
  logic                            rd_used;
  logic [fpfa_pkg::SIZE_BITS-1:0]  rd_size;
  logic                            fit;
  logic                            better;
  logic                            first_mode;
  logic                            last;
  logic [fpfa_pkg::CNT_W-1:0]      last_idx;

  assign item_ready = (state_r == ST_IDLE);
  assign accept     = item_valid && item_ready;
  assign load_wr    = accept && (item_mode == fpfa_pkg::MODE_LOAD) &&
                      (entry_count_r < fpfa_pkg::CNT_W'(fpfa_pkg::PARTITIONS));
  // Mark the picked entry used as the result leaves.
  assign mark_wr    = (state_r == ST_DONE) && res_ready && found_r;
  assign wr_en      = load_wr || mark_wr;
  assign wr_addr    = mark_wr ? pick_r : entry_count_r[fpfa_pkg::IDX_W-1:0];
  assign wr_data    = mark_wr ? {1'b1, pick_size_r} : {1'b0, item_size};

  // Read one entry ahead: address 0 while idle, the next index while scanning.
  assign rd_addr = (state_r == ST_SCAN) ? cmp_idx_r + 1'b1 : '0;
  assign rd_used = rd_data[fpfa_pkg::SIZE_BITS];
  assign rd_size = rd_data[fpfa_pkg::SIZE_BITS-1:0];

  fpfa_size_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    case (policy)
      fpfa_pkg::POL_BEST:  first_mode = 1'b0;
      fpfa_pkg::POL_WORST: first_mode = 1'b0;
      default:             first_mode = 1'b1;
    endcase
    fit    = !rd_used && (rd_size >= req_size_r);
    better = !found_r ||
             ((policy == fpfa_pkg::POL_BEST)  && (rd_size < pick_size_r)) ||
             ((policy == fpfa_pkg::POL_WORST) && (rd_size > pick_size_r));
    last_idx = entry_count_r - 1'b1;
    last     = ({1'b0, cmp_idx_r} == last_idx) || (fit && first_mode);
  end

  assign res_valid                = (state_r == ST_DONE);
  assign res.granted              = found_r;
  assign res.partition_index      = found_r ? fpfa_pkg::PIDX_W'(pick_r) : '0;
  assign res.request_number       = request_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      entry_count_r   <= '0;
      request_count_r <= '0;
      found_r         <= 1'b0;
      pick_r          <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            case (item_mode)
              fpfa_pkg::MODE_CLEAR: begin
                // Stale used marks are overwritten as entries are loaded again.
                entry_count_r   <= '0;
                request_count_r <= '0;
              end
              fpfa_pkg::MODE_LOAD: begin
                if (load_wr) begin
                  entry_count_r <= entry_count_r + 1'b1;
                end
              end
              fpfa_pkg::MODE_REQUEST: begin
                req_size_r <= item_size;
                cmp_idx_r  <= '0;
                found_r    <= 1'b0;
                pick_r     <= '0;
                state_r    <= (entry_count_r == '0) ? ST_DONE : ST_SCAN;
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (fit && better) begin
            found_r     <= 1'b1;
            pick_r      <= cmp_idx_r;
            pick_size_r <= rd_size;
          end
          if (last) begin
            state_r <= ST_DONE;
          end else begin
            cmp_idx_r <= cmp_idx_r + 1'b1;
          end
        end
        ST_DONE: begin
          // Hold the result until the output stage takes it.
          if (res_ready) begin
            request_count_r <= request_count_r + 1'b1;
            state_r         <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/core/fixed_partition_fit_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_partition_fit_allocator
// Fixed partition table with first, best and worst fit allocation.
// ----------------------------------------------------------------------------
// Clear and load items are each handled in the idle state. A request scans
// the loaded table entries: all of them for best and worst fit, up to the
// first fitting one for first fit, and on an empty table it goes straight to
// the result. The scan reads the partition size table through its single
// read port, one entry per cycle, up to all 128 entries of a full table.
// The result sits in an output register; a request whose result cannot be
// stored waits in the block until the register drains.
// ----------------------------------------------------------------------------
module fixed_partition_fit_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] size
  input  logic [1:0]  in_tuser,   // [1:0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [0] granted, [7:1] partition_index,
                                  // [23:8] request_number
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data    // fit_policy
);

  logic [fpfa_pkg::POL_W-1:0] policy_r;
  logic                       out_valid_r;
  fpfa_pkg::result_t          out_data_r;
  logic                       res_valid;
  logic                       res_ready;
  fpfa_pkg::result_t          res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= fpfa_pkg::POL_FIRST;
    end else if (cfg_valid) begin
      policy_r <= cfg_data;
    end
  end

  fpfa_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_tvalid),
    .item_ready (in_tready),
    .item_mode  (in_tuser),
    .item_size  (in_tdata[fpfa_pkg::SIZE_BITS-1:0]),
    .policy     (policy_r),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### bench/tb_fixed_partition_fit_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_partition_fit_allocator
// Drives clear, load and request transfers into the partition allocator under
// every fit policy. A local copy of the partition table predicts each grant,
// and a scoreboard compares every result transfer field by field.
// ----------------------------------------------------------------------------
module tb_fixed_partition_fit_allocator;

  localparam logic [fpfa_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam logic [fpfa_pkg::POL_W-1:0]  POL_UNUSED  = 2'd3;
  localparam int SETTLE_CYCLES  = fpfa_pkg::PARTITIONS + 12;
  localparam int CYCLE_LIMIT    = 4_000_000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [15:0] size
  logic [1:0]  in_tuser;   // [1:0] mode
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // [0] granted, [7:1] partition_index, [23:8] request_number
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_data;   // fit_policy

  // Local copy of the partition table
  logic [fpfa_pkg::SIZE_BITS-1:0] part_size [fpfa_pkg::PARTITIONS];
  bit                             part_used [fpfa_pkg::PARTITIONS];
  int                             part_count;
  logic [fpfa_pkg::REQ_W-1:0]     req_count;
  logic [fpfa_pkg::POL_W-1:0]     policy_model;

  fpfa_pkg::result_t pending_grants [$];
  fpfa_pkg::result_t got_grant;
  fpfa_pkg::result_t want_grant;
  int                mismatch_count;
  int                cycle_count;

  // Sender and receiver pacing
  bit tx_idle_en;
  int burst_left;
  bit rx_stall_en;
  bit rx_ready_phase;
  int rx_left;

  fixed_partition_fit_allocator uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("fixed_partition_fit_allocator: mismatch");
      $finish;
    end
  end

  // Predict one request and update the table copy
  function automatic fpfa_pkg::result_t allocate_partition(
    input logic [fpfa_pkg::SIZE_BITS-1:0] want_size);
    fpfa_pkg::result_t res;
    bit                found;
    int                pick;
    int                j;
    found = 1'b0;
    pick  = 0;
    for (j = 0; j < part_count; j++) begin
      if (!part_used[j] && part_size[j] >= want_size) begin
        if (!found) begin
          found = 1'b1;
          pick  = j;
          if (policy_model != fpfa_pkg::POL_BEST && policy_model != fpfa_pkg::POL_WORST)
            break;
        end else if (policy_model == fpfa_pkg::POL_BEST &&
                     part_size[j] < part_size[pick]) begin
          pick = j;
        end else if (policy_model == fpfa_pkg::POL_WORST &&
                     part_size[j] > part_size[pick]) begin
          pick = j;
        end
      end
    end
    if (found) part_used[pick] = 1'b1;
    res.granted         = found;
    res.partition_index = found ? fpfa_pkg::PIDX_W'(pick) : '0;
    res.request_number  = req_count;
    req_count           = req_count + 1'b1;
    return res;
  endfunction

  task automatic clear_table_copy();
    int j;
    for (j = 0; j < fpfa_pkg::PARTITIONS; j++) part_used[j] = 1'b0;
    part_count = 0;
    req_count  = '0;
  endtask

  task automatic apply_item(input logic [1:0] mode, input logic [15:0] size);
    case (mode)
      fpfa_pkg::MODE_CLEAR: begin
        clear_table_copy();
      end
      fpfa_pkg::MODE_LOAD: begin
        if (part_count < fpfa_pkg::PARTITIONS) begin
          part_size[part_count] = size;
          part_used[part_count] = 1'b0;
          part_count++;
        end
      end
      fpfa_pkg::MODE_REQUEST: begin
        pending_grants.push_back(allocate_partition(size));
      end
      default: ;
    endcase
  endtask

  task automatic flag_mismatch(input string what, input fpfa_pkg::result_t want,
                               input fpfa_pkg::result_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t %s: expected granted=%0d index=%0d number=%0d", $realtime, what,
               want.granted, want.partition_index, want.request_number);
      $display("%0t %s: actual   granted=%0d index=%0d number=%0d", $realtime, what,
               got.granted, got.partition_index, got.request_number);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_grant = out_tdata;
      if (pending_grants.size() == 0) begin
        flag_mismatch("unexpected result", '0, got_grant);
      end else begin
        want_grant = pending_grants.pop_front();
        if (got_grant.granted != want_grant.granted ||
            got_grant.partition_index != want_grant.partition_index ||
            got_grant.request_number != want_grant.request_number)
          flag_mismatch("result", want_grant, got_grant);
      end
    end
  end

  // Receiver: alternate ready and stall runs of random length
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!rx_stall_en) begin
        out_tready = 1'b1;
      end else begin
        if (rx_left == 0) begin
          rx_ready_phase = !rx_ready_phase;
          if (rx_ready_phase) rx_left = $urandom_range(1, 16);
          else rx_left = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40)
                                                      : $urandom_range(1, 6);
        end
        out_tready = rx_ready_phase;
        rx_left--;
      end
    end
  end

  task automatic send_item(input logic [1:0] mode, input logic [15:0] size);
    int gap;
    if (tx_idle_en && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(7, SETTLE_CYCLES)
                                        : $urandom_range(0, 6);
      if (gap != 0) begin
        @(negedge clk);
        in_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = mode;
    in_tdata  = size;
    do @(posedge clk); while (!in_tready);
    apply_item(mode, size);
    if (burst_left > 0) burst_left--;
  endtask

  // Drop valid, wait for all results, then let a trailing scan finish
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_policy(input logic [1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    policy_model = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [15:0] pick_size(input int scale);
    case ($urandom_range(0, 15))
      0: return 16'd0;
      1: return 16'hFFFF;
      default: begin
        case (scale)
          0:       return 16'($urandom_range(0, 15));
          1:       return 16'($urandom_range(0, 1023));
          default: return 16'($urandom);
        endcase
      end
    endcase
  endfunction

  task automatic test_directed();
    tx_idle_en  = 1'b0;
    rx_stall_en = 1'b0;
    // First fit from reset, empty table first
    send_item(fpfa_pkg::MODE_REQUEST, 16'd0);
    send_item(fpfa_pkg::MODE_LOAD, 16'd0);
    send_item(fpfa_pkg::MODE_LOAD, 16'hFFFF);
    send_item(fpfa_pkg::MODE_LOAD, 16'd100);
    send_item(fpfa_pkg::MODE_LOAD, 16'd50);
    send_item(fpfa_pkg::MODE_LOAD, 16'd100);
    send_item(fpfa_pkg::MODE_REQUEST, 16'd0);
    send_item(fpfa_pkg::MODE_REQUEST, 16'd0);
    send_item(fpfa_pkg::MODE_REQUEST, 16'hFFFF);  // largest entry already used
    send_item(fpfa_pkg::MODE_REQUEST, 16'd60);
    send_item(fpfa_pkg::MODE_REQUEST, 16'd60);
    send_item(fpfa_pkg::MODE_REQUEST, 16'd60);    // nothing left that fits
    send_item(MODE_UNUSED, 16'hFFFF);
    send_item(fpfa_pkg::MODE_CLEAR, 16'hFFFF);
    send_item(fpfa_pkg::MODE_REQUEST, 16'd0);
    write_policy(fpfa_pkg::POL_BEST);
    send_item(fpfa_pkg::MODE_LOAD, 16'd30);
    send_item(fpfa_pkg::MODE_LOAD, 16'd10);
    send_item(fpfa_pkg::MODE_LOAD, 16'd20);
    send_item(fpfa_pkg::MODE_LOAD, 16'd10);
    send_item(fpfa_pkg::MODE_REQUEST, 16'd10);
    send_item(fpfa_pkg::MODE_REQUEST, 16'd10);
    send_item(fpfa_pkg::MODE_REQUEST, 16'd5);
    write_policy(fpfa_pkg::POL_WORST);
    send_item(fpfa_pkg::MODE_LOAD, 16'd30);
    send_item(fpfa_pkg::MODE_REQUEST, 16'd5);
    send_item(fpfa_pkg::MODE_REQUEST, 16'd5);
  endtask

  task automatic test_full_table();
    int i;
    tx_idle_en  = 1'b1;
    rx_stall_en = 1'b1;
    write_policy(fpfa_pkg::POL_WORST);
    send_item(fpfa_pkg::MODE_CLEAR, 16'd0);
    for (i = 0; i < fpfa_pkg::PARTITIONS - 1; i++)
      send_item(fpfa_pkg::MODE_LOAD, 16'($urandom_range(0, 60000)));
    send_item(fpfa_pkg::MODE_LOAD, 16'hFFFF);
    // Table full: drop these
    send_item(fpfa_pkg::MODE_LOAD, 16'hFFFF);
    send_item(fpfa_pkg::MODE_LOAD, 16'd0);
    send_item(fpfa_pkg::MODE_REQUEST, 16'hFFFF);
    send_item(fpfa_pkg::MODE_REQUEST, 16'hFFFF);
    repeat (8) send_item(fpfa_pkg::MODE_REQUEST, 16'($urandom));
    write_policy(fpfa_pkg::POL_BEST);
    repeat (5) send_item(fpfa_pkg::MODE_REQUEST, 16'($urandom_range(0, 60000)));
    write_policy(fpfa_pkg::POL_FIRST);
    repeat (5) send_item(fpfa_pkg::MODE_REQUEST, 16'($urandom_range(0, 60000)));
    write_policy(POL_UNUSED);
    repeat (5) send_item(fpfa_pkg::MODE_REQUEST, 16'($urandom_range(0, 60000)));
  endtask

  task automatic test_random_traffic(input int target);
    int sent;
    int phase;
    int entries;
    int ops;
    int scale;
    int r;
    int i;
    sent  = 0;
    phase = 0;
    while (sent < target) begin
      write_policy((phase < 4) ? 2'(phase) : 2'($urandom_range(0, 3)));
      tx_idle_en  = ($urandom_range(0, 3) != 0);
      rx_stall_en = ($urandom_range(0, 3) != 0);
      scale   = $urandom_range(0, 2);
      entries = ($urandom_range(0, 9) == 0) ? $urandom_range(24, fpfa_pkg::PARTITIONS + 4)
                                            : $urandom_range(1, 20);
      send_item(fpfa_pkg::MODE_CLEAR, 16'($urandom));
      for (i = 0; i < entries; i++) send_item(fpfa_pkg::MODE_LOAD, pick_size(scale));
      sent += 1 + entries;
      ops = $urandom_range(entries, 2 * entries + 4);
      repeat (ops) begin
        r = $urandom_range(0, 99);
        if (r < 70)      send_item(fpfa_pkg::MODE_REQUEST, pick_size(scale));
        else if (r < 88) send_item(fpfa_pkg::MODE_LOAD, pick_size(scale));
        else if (r < 93) send_item(fpfa_pkg::MODE_CLEAR, 16'($urandom));
        else             send_item(MODE_UNUSED, 16'($urandom));
        if (r < 93) sent++;
      end
      phase++;
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = fpfa_pkg::MODE_CLEAR;
    cfg_valid      = 1'b0;
    cfg_data       = fpfa_pkg::POL_FIRST;
    mismatch_count = 0;
    cycle_count    = 0;
    tx_idle_en     = 1'b0;
    burst_left     = 0;
    rx_stall_en    = 1'b0;
    rx_ready_phase = 1'b0;
    rx_left        = 0;
    policy_model   = fpfa_pkg::POL_FIRST;
    clear_table_copy();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_full_table();
    test_random_traffic(1650);

    wait_idle();
    if (mismatch_count == 0 && pending_grants.size() == 0) begin
      $display("fixed_partition_fit_allocator: match");
    end else begin
      $display("fixed_partition_fit_allocator: mismatch");
    end
    $finish;
  end

endmodule
